[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions; empty when synthesising.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// A property that must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// A condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

[rtl/cjm_pkg.sv]
// ----------------------------------------------------------------------------
// cjm_pkg
// Types, sizes and codes shared by the cron job matcher and its cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cjm_pkg;

    // Table size and pattern encoding.
    localparam int MAX_JOBS  = 16;
    localparam logic [7:0] STAR_CODE = 8'd255;
    localparam int PAT_W     = 40;
    localparam int CNT_W     = $clog2(MAX_JOBS + 1);
    localparam int ID_W      = CNT_W;
    localparam int TARGET_W  = 7;
    localparam int JOB_ID_W  = 5;

    // Item kinds.
    localparam logic [1:0] MODE_TICK = 2'd0;
    localparam logic [1:0] MODE_ADD  = 2'd1;
    localparam logic [1:0] MODE_DEL  = 2'd2;

    // Result codes.
    localparam logic [2:0] ST_FIRED     = 3'd0;
    localparam logic [2:0] ST_NO_MATCH  = 3'd1;
    localparam logic [2:0] ST_ADDED     = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_DELETED   = 3'd4;
    localparam logic [2:0] ST_NOT_FOUND = 3'd5;
    localparam logic [2:0] ST_DISABLED  = 3'd6;

    typedef struct packed {
        logic [1:0]          mode;
        logic [7:0]          minute;
        logic [7:0]          hour;
        logic [7:0]          mday;
        logic [7:0]          month_num;
        logic [7:0]          weekday;
        logic [TARGET_W-1:0] target_id;
    } cjm_req_t;

    typedef struct packed {
        logic [2:0]          status;
        logic [JOB_ID_W-1:0] job_id;
        logic                last;
    } cjm_rsp_t;

    // Commands broadcast from the sequencer to every cell.
    typedef struct packed {
        logic capture;
        logic scan_shift;
        logic find;
        logic remove;
        logic append;
    } cjm_cell_ctrl_t;

endpackage

[rtl/cjm_cell.sv]
// ----------------------------------------------------------------------------
// cjm_cell
// One table slot: a job's patterns and id, a match flag and id for the
// result scan, and a hit flag for deletion. Data moves towards slot 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cjm_cell (
    input  logic                          clk,
    input  cjm_pkg::cjm_cell_ctrl_t       ctrl,
    input  logic [cjm_pkg::CNT_W-1:0]     index,
    input  logic [cjm_pkg::CNT_W-1:0]     count,
    input  logic [cjm_pkg::PAT_W-1:0]     key,
    input  logic [cjm_pkg::TARGET_W-1:0]  target,
    input  logic [cjm_pkg::ID_W-1:0]      new_id,
    input  logic [cjm_pkg::PAT_W-1:0]     nb_pat,
    input  logic [cjm_pkg::ID_W-1:0]      nb_id,
    input  logic                          nb_match,
    input  logic [cjm_pkg::ID_W-1:0]      nb_sid,
    input  logic                          prefix_in,
    output logic [cjm_pkg::PAT_W-1:0]     pat,
    output logic [cjm_pkg::ID_W-1:0]      id,
    output logic                          match,
    output logic [cjm_pkg::ID_W-1:0]      sid,
    output logic                          prefix_out,
    output logic [cjm_pkg::MAX_JOBS:0]    used
);

    logic [cjm_pkg::PAT_W-1:0] pat_reg;
    logic [cjm_pkg::ID_W-1:0]  id_reg;
    logic                      match_reg;
    logic [cjm_pkg::ID_W-1:0]  sid_reg;
    logic                      hit_reg;
    logic                      occupied;
    logic                      pattern_hit;
    logic                      shift_here;

    // One pattern byte matches on the wildcard or on equality.
    function automatic logic field_match(input logic [7:0] p, input logic [7:0] now);
        return (p == cjm_pkg::STAR_CODE) || (p == now);
    endfunction

    // The slot holds a job when it lies below the fill count.
    assign occupied = (index < count);

    always_comb
    begin
        pattern_hit = 1'b1;
        for (int f = 0; f < 5; f++)
        begin
            if (!field_match(pat_reg[8*f +: 8], key[8*f +: 8]))
            begin
                pattern_hit = 1'b0;
            end
        end
    end

    // Slots at and after the deleted one take their right neighbour's job.
    assign shift_here = prefix_in || hit_reg;
    assign prefix_out = shift_here;

    // Decoded id, so that the sequencer can find the lowest free one.
    always_comb
    begin
        for (int k = 0; k <= cjm_pkg::MAX_JOBS; k++)
        begin
            used[k] = occupied && (id_reg == cjm_pkg::ID_W'(k));
        end
    end

    // Job storage.
    always_ff @(posedge clk)
    begin
        if (ctrl.remove && shift_here)
        begin
            pat_reg <= nb_pat;
            id_reg  <= nb_id;
        end
        else if (ctrl.append && (index == count))
        begin
            pat_reg <= key;
            id_reg  <= new_id;
        end
    end

    // Result scan chain and delete hit flag.
    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            match_reg <= occupied && pattern_hit;
            sid_reg   <= id_reg;
        end
        else if (ctrl.scan_shift)
        begin
            match_reg <= nb_match;
            sid_reg   <= nb_sid;
        end
        if (ctrl.find)
        begin
            hit_reg <= occupied && (cjm_pkg::TARGET_W'(id_reg) == target);
        end
    end

    assign pat   = pat_reg;
    assign id    = id_reg;
    assign match = match_reg;
    assign sid   = sid_reg;

endmodule

[rtl/cron_job_matcher.sv]
// ----------------------------------------------------------------------------
// cron_job_matcher
// A tick latches every slot's match flag and scans the flags out from the
// head; an add finds a free id and writes, a delete finds and shifts, and a
// disabled tick or an add to a full table just replies. Stalls hold replies.
// One item is in work at a time; the next is taken once its last result has
// gone to the output register. Reset clears the fill count, the enable bit
// and all control state at once; there is no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module cron_job_matcher (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    input  logic              req_valid,
    output logic              req_stall,
    input  cjm_pkg::cjm_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output cjm_pkg::cjm_rsp_t rsp
);

    localparam int N = cjm_pkg::MAX_JOBS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK_CAP,
        ST_SCAN,
        ST_ADD_FIND,
        ST_ADD_WRITE,
        ST_DEL_FIND,
        ST_DEL_SHIFT,
        ST_REPLY
    } state_t;

    state_t                         state_reg, state_next;
    logic [cjm_pkg::CNT_W-1:0]      count_reg, count_next;
    logic                           enabled_reg, enabled_next;
    cjm_pkg::cjm_req_t              cmd_reg, cmd_next;
    logic [cjm_pkg::ID_W-1:0]       new_id_reg, new_id_next;
    logic [2:0]                     res_status_reg, res_status_next;
    logic [cjm_pkg::JOB_ID_W-1:0]   res_id_reg, res_id_next;
    logic                           rsp_valid_reg, rsp_valid_next;
    cjm_pkg::cjm_rsp_t              rsp_reg, rsp_next;

    cjm_pkg::cjm_cell_ctrl_t        ctrl;
    logic [cjm_pkg::PAT_W-1:0]      key;
    logic [cjm_pkg::PAT_W-1:0]      cell_pat [N];
    logic [cjm_pkg::ID_W-1:0]       cell_id [N];
    logic                           cell_match [N];
    logic [cjm_pkg::ID_W-1:0]       cell_sid [N];
    logic [N:0]                     cell_used [N];
    logic [N:0]                     prefix;
    logic [N:0]                     used_all;
    logic [cjm_pkg::ID_W-1:0]       free_id;
    logic                           rest_any;
    logic                           out_free;
    logic                           del_found;

    // Time on a tick, job patterns on an add.
    assign key = {cmd_reg.weekday, cmd_reg.month_num, cmd_reg.mday,
                  cmd_reg.hour, cmd_reg.minute};

    // Row of slots; slot 0 is the oldest job and the head of the scan.
    assign prefix[0] = 1'b0;

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        logic [cjm_pkg::PAT_W-1:0] nb_pat;
        logic [cjm_pkg::ID_W-1:0]  nb_id;
        logic                      nb_match;
        logic [cjm_pkg::ID_W-1:0]  nb_sid;

        if (i == N - 1)
        begin : g_tail
            assign nb_pat   = '0;
            assign nb_id    = '0;
            assign nb_match = 1'b0;
            assign nb_sid   = '0;
        end
        else
        begin : g_body
            assign nb_pat   = cell_pat[i+1];
            assign nb_id    = cell_id[i+1];
            assign nb_match = cell_match[i+1];
            assign nb_sid   = cell_sid[i+1];
        end

        cjm_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .index      (cjm_pkg::CNT_W'(i)),
            .count      (count_reg),
            .key        (key),
            .target     (cmd_reg.target_id),
            .new_id     (new_id_reg),
            .nb_pat     (nb_pat),
            .nb_id      (nb_id),
            .nb_match   (nb_match),
            .nb_sid     (nb_sid),
            .prefix_in  (prefix[i]),
            .pat        (cell_pat[i]),
            .id         (cell_id[i]),
            .match      (cell_match[i]),
            .sid        (cell_sid[i]),
            .prefix_out (prefix[i+1]),
            .used       (cell_used[i])
        );
    end

    assign del_found = prefix[N];

    // Any match still waiting behind the head slot.
    always_comb
    begin
        rest_any = 1'b0;
        for (int i = 1; i < N; i++)
        begin
            rest_any = rest_any | cell_match[i];
        end
    end

    // Lowest id from 1 that no stored job holds.
    always_comb
    begin
        used_all = '0;
        for (int i = 0; i < N; i++)
        begin
            used_all = used_all | cell_used[i];
        end
        free_id = '0;
        for (int k = N; k >= 1; k--)
        begin
            if (!used_all[k])
            begin
                free_id = cjm_pkg::ID_W'(k);
            end
        end
    end

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != ST_IDLE);

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        enabled_next    = enabled_reg;
        cmd_next        = cmd_reg;
        new_id_next     = new_id_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        rsp_next        = rsp_reg;
        ctrl            = '0;

        if (cfg_wr_en)
        begin
            enabled_next = cfg_wr_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next = req;
                    case (req.mode)
                        cjm_pkg::MODE_TICK:
                        begin
                            if (enabled_reg)
                            begin
                                state_next = ST_TICK_CAP;
                            end
                            else
                            begin
                                res_status_next = cjm_pkg::ST_DISABLED;
                                res_id_next     = '0;
                                state_next      = ST_REPLY;
                            end
                        end
                        cjm_pkg::MODE_ADD:
                        begin
                            if (count_reg >= cjm_pkg::CNT_W'(N))
                            begin
                                res_status_next = cjm_pkg::ST_FULL;
                                res_id_next     = '0;
                                state_next      = ST_REPLY;
                            end
                            else
                            begin
                                state_next = ST_ADD_FIND;
                            end
                        end
                        cjm_pkg::MODE_DEL:
                        begin
                            state_next = ST_DEL_FIND;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_TICK_CAP:
            begin
                ctrl.capture = 1'b1;
                state_next   = ST_SCAN;
            end

            // The head slot is reported when it matched; the chain then
            // moves on by one slot.
            ST_SCAN:
            begin
                if (cell_match[0])
                begin
                    if (out_free)
                    begin
                        rsp_valid_next  = 1'b1;
                        rsp_next.status = cjm_pkg::ST_FIRED;
                        rsp_next.job_id = cjm_pkg::JOB_ID_W'(cell_sid[0]);
                        rsp_next.last   = !rest_any;
                        ctrl.scan_shift = 1'b1;
                        if (!rest_any)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
                else if (rest_any)
                begin
                    ctrl.scan_shift = 1'b1;
                end
                else if (out_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_next.status = cjm_pkg::ST_NO_MATCH;
                    rsp_next.job_id = '0;
                    rsp_next.last   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            ST_ADD_FIND:
            begin
                new_id_next = free_id;
                state_next  = ST_ADD_WRITE;
            end

            ST_ADD_WRITE:
            begin
                ctrl.append     = 1'b1;
                count_next      = count_reg + 1'b1;
                res_status_next = cjm_pkg::ST_ADDED;
                res_id_next     = cjm_pkg::JOB_ID_W'(new_id_reg);
                state_next      = ST_REPLY;
            end

            ST_DEL_FIND:
            begin
                ctrl.find  = 1'b1;
                state_next = ST_DEL_SHIFT;
            end

            ST_DEL_SHIFT:
            begin
                if (del_found)
                begin
                    ctrl.remove     = 1'b1;
                    count_next      = count_reg - 1'b1;
                    res_status_next = cjm_pkg::ST_DELETED;
                    res_id_next     = cjm_pkg::JOB_ID_W'(cmd_reg.target_id);
                end
                else
                begin
                    res_status_next = cjm_pkg::ST_NOT_FOUND;
                    res_id_next     = '0;
                end
                state_next = ST_REPLY;
            end

            ST_REPLY:
            begin
                if (out_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_next.status = res_status_reg;
                    rsp_next.job_id = res_id_reg;
                    rsp_next.last   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, table fill count and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            enabled_reg    <= 1'b0;
            cmd_reg        <= '0;
            new_id_reg     <= '0;
            res_status_reg <= '0;
            res_id_reg     <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            enabled_reg    <= enabled_next;
            cmd_reg        <= cmd_next;
            new_id_reg     <= new_id_next;
            res_status_reg <= res_status_next;
            res_id_reg     <= res_id_next;
            rsp_valid_reg  <= rsp_valid_next;
            rsp_reg        <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Checks on the sequencer.
    `ASSERT_NEVER(a_count_max, clk, rst_n, count_reg > cjm_pkg::CNT_W'(N), "job count beyond table size")
    `ASSERT_PROP(a_add_grows, clk, rst_n, state_reg == ST_ADD_WRITE |=> count_reg == $past(count_reg) + 1'b1, "add did not grow the table")
    `ASSERT_PROP(a_new_id_range, clk, rst_n, state_reg == ST_ADD_WRITE |-> (new_id_reg != '0 && {1'b0, new_id_reg} <= {1'b0, count_reg} + 1'b1), "allocated id out of range")
    `ASSERT_PROP(a_count_moves, clk, rst_n, count_reg != $past(count_reg) |-> ($past(state_reg) == ST_ADD_WRITE || $past(state_reg) == ST_DEL_SHIFT), "job count changed outside add or delete")

endmodule

[test/tb_cron_job_matcher.sv]
// ----------------------------------------------------------------------------
// tb_cron_job_matcher
// Self-checking testbench for the cron job matcher. A behavioural copy of the
// job table predicts every result of each accepted request; a checker compares
// the response stream field by field against those predictions, while both
// sides of the handshake idle in random bursts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_cron_job_matcher;

    // Mode value that the block must ignore without a result.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Cycles left for the block to finish work after the last result.
    localparam int SETTLE_CYCLES = cjm_pkg::MAX_JOBS + 8;
    // Cycles without any transfer before the run is declared hung.
    localparam int HANG_LIMIT    = 3000;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic              cfg_wr_data = 1'b0;
    logic              req_valid   = 1'b0;
    logic              req_stall;
    cjm_pkg::cjm_req_t req         = '0;
    logic              rsp_valid;
    logic              rsp_stall   = 1'b0;
    cjm_pkg::cjm_rsp_t rsp;

    // Behavioural copy of the job table and the enable register.
    logic [cjm_pkg::PAT_W-1:0] slot_pat [cjm_pkg::MAX_JOBS];
    int unsigned               slot_id  [cjm_pkg::MAX_JOBS];
    int unsigned               job_fill;
    bit                        sched_enabled;

    cjm_pkg::cjm_rsp_t pending_rsp[$];
    cjm_pkg::cjm_rsp_t oldest_rsp;
    int                error_count = 0;
    int                hang_cycles = 0;
    bit                idle_on     = 1'b1;
    int                stall_left  = 0;

    cron_job_matcher uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp)
    );

    initial
    begin
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // Queue one predicted response.
    function automatic void queue_result(input logic [2:0] status, input int unsigned id,
                                         input logic last);
        cjm_pkg::cjm_rsp_t r;
        r.status = status;
        r.job_id = id[cjm_pkg::JOB_ID_W-1:0];
        r.last   = last;
        pending_rsp.insert(pending_rsp.size(), r);
    endfunction

    // Work out the responses of one accepted request and update the table.
    function automatic void predict_results(input cjm_pkg::cjm_req_t item);
        logic [cjm_pkg::PAT_W-1:0] now;
        logic [7:0]                p;
        int unsigned               new_id;
        int                        hits;
        int                        pos;
        bit                        hit;
        bit                        taken;
        now = {item.weekday, item.month_num, item.mday, item.hour, item.minute};
        case (item.mode)
            cjm_pkg::MODE_TICK:
            begin
                if (!sched_enabled)
                begin
                    queue_result(cjm_pkg::ST_DISABLED, 0, 1'b1);
                end
                else
                begin
                    hits = 0;
                    for (int i = 0; i < job_fill; i++)
                    begin
                        hit = 1'b1;
                        for (int f = 0; f < 5; f++)
                        begin
                            p = slot_pat[i][8*f +: 8];
                            if (p != cjm_pkg::STAR_CODE && p != now[8*f +: 8])
                                hit = 1'b0;
                        end
                        if (hit)
                        begin
                            queue_result(cjm_pkg::ST_FIRED, slot_id[i], 1'b0);
                            hits++;
                        end
                    end
                    if (hits == 0)
                        queue_result(cjm_pkg::ST_NO_MATCH, 0, 1'b1);
                    else
                        pending_rsp[pending_rsp.size() - 1].last = 1'b1;
                end
            end
            cjm_pkg::MODE_ADD:
            begin
                if (job_fill >= cjm_pkg::MAX_JOBS)
                begin
                    queue_result(cjm_pkg::ST_FULL, 0, 1'b1);
                end
                else
                begin
                    // Lowest id from 1 that no stored job holds.
                    new_id = 1;
                    do
                    begin
                        taken = 1'b0;
                        for (int i = 0; i < job_fill; i++)
                            if (slot_id[i] == new_id)
                                taken = 1'b1;
                        if (taken)
                            new_id++;
                    end
                    while (taken);
                    slot_pat[job_fill] = now;
                    slot_id[job_fill]  = new_id;
                    job_fill++;
                    queue_result(cjm_pkg::ST_ADDED, new_id, 1'b1);
                end
            end
            cjm_pkg::MODE_DEL:
            begin
                pos = -1;
                for (int i = 0; i < job_fill; i++)
                    if (pos < 0 && slot_id[i] == item.target_id)
                        pos = i;
                if (pos < 0)
                begin
                    queue_result(cjm_pkg::ST_NOT_FOUND, 0, 1'b1);
                end
                else
                begin
                    // Close the gap and keep the order of the remaining jobs.
                    for (int j = pos; j + 1 < job_fill; j++)
                    begin
                        slot_pat[j] = slot_pat[j + 1];
                        slot_id[j]  = slot_id[j + 1];
                    end
                    job_fill--;
                    queue_result(cjm_pkg::ST_DELETED, item.target_id, 1'b1);
                end
            end
            default:
            begin
                // The unused mode leaves everything as it is.
            end
        endcase
    endfunction

    function automatic cjm_pkg::cjm_req_t build_req(
        input logic [1:0] mode, input logic [7:0] mi,
        input logic [7:0] hr, input logic [7:0] dm,
        input logic [7:0] mo, input logic [7:0] wd,
        input logic [cjm_pkg::TARGET_W-1:0] tid);
        cjm_pkg::cjm_req_t r;
        r.mode      = mode;
        r.minute    = mi;
        r.hour      = hr;
        r.mday      = dm;
        r.month_num = mo;
        r.weekday   = wd;
        r.target_id = tid;
        return r;
    endfunction

    // A pattern or time byte drawn mostly from a narrow range so that ticks hit.
    function automatic logic [7:0] random_byte();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return cjm_pkg::STAR_CODE;
        else if (roll < 85)
            return 8'($urandom_range(0, 3));
        else
            return 8'($urandom_range(0, 255));
    endfunction

    function automatic cjm_pkg::cjm_req_t random_req();
        cjm_pkg::cjm_req_t r;
        int                roll;
        roll = $urandom_range(0, 99);
        r = build_req(cjm_pkg::MODE_TICK, random_byte(), random_byte(), random_byte(),
                      random_byte(), random_byte(), 7'($urandom_range(0, 127)));
        if (roll < 45)
        begin
            r.mode = cjm_pkg::MODE_TICK;
        end
        else if (roll < 77)
        begin
            r.mode = cjm_pkg::MODE_ADD;
        end
        else if (roll < 96)
        begin
            r.mode = cjm_pkg::MODE_DEL;
            roll = $urandom_range(0, 99);
            if (roll < 60 && job_fill > 0)
                r.target_id = 7'(slot_id[$urandom_range(0, job_fill - 1)]);
            else if (roll < 85)
                r.target_id = 7'($urandom_range(0, cjm_pkg::MAX_JOBS + 1));
        end
        else
        begin
            r.mode = MODE_UNUSED;
        end
        return r;
    endfunction

    // Present one request, hold it until the transfer, then predict its results.
    task automatic send_req(input cjm_pkg::cjm_req_t item);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (!(req_valid && !req_stall));
        predict_results(item);
    endtask

    // Wait until every predicted result has arrived and the block is quiet.
    task automatic drain();
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_enable(input bit value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sched_enabled = value;
    endtask

    // Ticks, an add and a delete while disabled, then matching at the byte extremes.
    task automatic test_disabled_and_extremes();
        send_req(build_req(cjm_pkg::MODE_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 7'd0));
        send_req(build_req(cjm_pkg::MODE_ADD, cjm_pkg::STAR_CODE, cjm_pkg::STAR_CODE,
                           cjm_pkg::STAR_CODE, cjm_pkg::STAR_CODE, cjm_pkg::STAR_CODE,
                           7'd127));
        send_req(build_req(cjm_pkg::MODE_TICK, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 7'd0));
        send_req(build_req(cjm_pkg::MODE_DEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 7'd0));
        write_enable(1'b1);
        send_req(build_req(cjm_pkg::MODE_TICK, 8'd9, 8'd9, 8'd9, 8'd9, 8'd9, 7'd127));
        send_req(build_req(cjm_pkg::MODE_ADD, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 7'd0));
        send_req(build_req(cjm_pkg::MODE_ADD, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254,
                           7'd0));
        send_req(build_req(cjm_pkg::MODE_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 7'd0));
        send_req(build_req(cjm_pkg::MODE_TICK, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254,
                           7'd0));
        send_req(build_req(cjm_pkg::MODE_TICK, cjm_pkg::STAR_CODE, cjm_pkg::STAR_CODE,
                           cjm_pkg::STAR_CODE, cjm_pkg::STAR_CODE, cjm_pkg::STAR_CODE,
                           7'd0));
    endtask

    // Deletion of present and absent ids, id reuse and the ignored mode.
    task automatic test_delete_and_reuse();
        send_req(build_req(cjm_pkg::MODE_DEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 7'd2));
        send_req(build_req(cjm_pkg::MODE_DEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 7'd2));
        send_req(build_req(cjm_pkg::MODE_DEL, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
                           7'd127));
        send_req(build_req(cjm_pkg::MODE_ADD, 8'd5, cjm_pkg::STAR_CODE, cjm_pkg::STAR_CODE,
                           cjm_pkg::STAR_CODE, cjm_pkg::STAR_CODE, 7'd0));
        send_req(build_req(MODE_UNUSED, 8'd5, 8'd5, 8'd5, 8'd5, 8'd5, 7'd127));
        send_req(build_req(cjm_pkg::MODE_TICK, 8'd5, 8'd1, 8'd1, 8'd1, 8'd1, 7'd0));
        send_req(build_req(cjm_pkg::MODE_DEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 7'd1));
        send_req(build_req(cjm_pkg::MODE_TICK, 8'd7, 8'd7, 8'd7, 8'd7, 8'd7, 7'd0));
        write_enable(1'b0);
        send_req(build_req(cjm_pkg::MODE_TICK, 8'd5, 8'd1, 8'd1, 8'd1, 8'd1, 7'd0));
    endtask

    // Fill the table, overflow it, fire its wildcard jobs, free and refill slots, then empty it again.
    task automatic test_full_table();
        int unsigned order[$];
        write_enable(1'b1);
        while (job_fill < cjm_pkg::MAX_JOBS)
            send_req(build_req(cjm_pkg::MODE_ADD, cjm_pkg::STAR_CODE, cjm_pkg::STAR_CODE,
                               cjm_pkg::STAR_CODE, cjm_pkg::STAR_CODE, cjm_pkg::STAR_CODE,
                               7'($urandom_range(0, 127))));
        send_req(build_req(cjm_pkg::MODE_ADD, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 7'd0));
        send_req(build_req(cjm_pkg::MODE_ADD, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 7'd0));
        send_req(build_req(cjm_pkg::MODE_TICK, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 7'd0));
        send_req(build_req(cjm_pkg::MODE_DEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 7'd5));
        send_req(build_req(cjm_pkg::MODE_DEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 7'd1));
        send_req(build_req(cjm_pkg::MODE_DEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                           7'(cjm_pkg::MAX_JOBS)));
        repeat (3)
            send_req(build_req(cjm_pkg::MODE_ADD, random_byte(), random_byte(),
                               random_byte(), random_byte(), random_byte(), 7'd0));
        send_req(build_req(cjm_pkg::MODE_TICK, 8'd0, 8'd1, 8'd2, 8'd3, 8'd0, 7'd0));
        for (int i = 0; i < job_fill; i++)
            order.insert(order.size(), slot_id[i]);
        order.shuffle();
        foreach (order[i])
            send_req(build_req(cjm_pkg::MODE_DEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                               7'(order[i])));
    endtask

    // Random traffic in phases, with the enable changed between phases.
    task automatic test_random_traffic();
        for (int phase = 0; phase < 10; phase++)
        begin
            write_enable(phase % 4 != 3);
            idle_on = (phase < 8) && (phase != 5);
            repeat (28)
                send_req(random_req());
        end
        idle_on = 1'b0;
    endtask

    // Receiver side: random stall bursts while idling is on.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            rsp_stall  <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(1, 16) - 1;
            rsp_stall  <= 1'b1;
        end
        else
        begin
            rsp_stall <= 1'b0;
        end
    end

    // Compare each response transfer with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp.size() == 0)
            begin
                $display("%0t: unexpected response: expected none, got status %0d id %0d last %0d",
                         $time, rsp.status, rsp.job_id, rsp.last);
                error_count++;
            end
            else
            begin
                oldest_rsp = pending_rsp.pop_front();
                if (rsp.status !== oldest_rsp.status)
                begin
                    $display("%0t: status mismatch: expected %0d, got %0d",
                             $time, oldest_rsp.status, rsp.status);
                    error_count++;
                end
                if (rsp.job_id !== oldest_rsp.job_id)
                begin
                    $display("%0t: job_id mismatch: expected %0d, got %0d",
                             $time, oldest_rsp.job_id, rsp.job_id);
                    error_count++;
                end
                if (rsp.last !== oldest_rsp.last)
                begin
                    $display("%0t: last mismatch: expected %0d, got %0d",
                             $time, oldest_rsp.last, rsp.last);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles in which neither channel makes a transfer.
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            hang_cycles <= 0;
        else
            hang_cycles <= hang_cycles + 1;
        if (hang_cycles >= HANG_LIMIT)
        begin
            $display("cron_job_matcher verification failed");
            $finish;
        end
    end

    initial
    begin
        job_fill      = 0;
        sched_enabled = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_disabled_and_extremes();
        test_delete_and_reuse();
        test_full_table();
        test_random_traffic();
        drain();

        if (error_count == 0)
            $display("cron_job_matcher verification clean");
        else
            $display("cron_job_matcher verification failed");
        $finish;
    end

endmodule
